FILE: src/connection_timeout_queue_macros.svh
// Assertion macros used by the connection timeout queue checker
`ifndef CONNECTION_TIMEOUT_QUEUE_MACROS_SVH
`define CONNECTION_TIMEOUT_QUEUE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define CTQ_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CTQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/cto_pkg.sv
// Types and constants of the connection timeout queue
`timescale 1ns / 1ps

package cto_pkg;

    localparam int LINK_W    = 7;
    localparam int EPOCH_W   = 32;
    localparam int TIMEOUT_W = 16;
    localparam int FUNC_W    = 2;
    localparam int SLOT_W    = 6;
    localparam int VICTIM_W  = 6;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 8;

    localparam logic [LINK_W-1:0]    NO_LINK        = 7'd64;
    localparam logic [EPOCH_W-1:0]   EPOCH_MAX      = '1;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET  = 16'd15;

    localparam logic [FUNC_W-1:0] FUNC_TOUCH  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_FLUSH  = 2'd3;

    typedef struct packed {
        logic [VICTIM_W-1:0] victim;
        logic                reaped;
        logic                last;
        logic                empty;
    } result_t;

endpackage

FILE: src/connection_timeout_queue.sv
// Connection timeout queue: slots in an index-linked LRU list with tick-based reaping
`timescale 1ns / 1ps

// One item is taken at a time; s_axis_tready is high only while the sequencer is idle.
// Every op goes through one small sequencer around three single-port link/deadline
// memories and one shared 32-bit compare. Touch of a queued slot steps through accept,
// unlink, append, tail link and result, without the tail link when it was the only slot
// queued; touch of a free slot skips the unlink, and the tail link into an empty queue;
// remove goes accept, unlink, result, skipping the unlink for a slot not queued. Tick
// and flush accept, read and compare/unlink the head per reaped slot, stop at an empty
// queue or a live head, then give the result. Each result waits in one output register,
// so a stalled master side only holds the sequencer when a second result is ready to go out.
module connection_timeout_queue
    import cto_pkg::*;
#(
    parameter int MAX_CONNS = 64
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [TIMEOUT_W-1:0]     cfg_wdata,     // idle timeout in ticks
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [IN_TDATA_W-1:0]    s_axis_tdata,  // func[1:0], conn_index[7:2], keep_alive[8]
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [OUT_TDATA_W-1:0]   m_axis_tdata,  // victim_index[5:0], queue_empty[6]
    output logic                     m_axis_tuser,  // reaped
    output logic                     m_axis_tlast
);

    localparam int AW = (MAX_CONNS > 1) ? $clog2(MAX_CONNS) : 1;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_UNLINK = 3'd1;
    localparam logic [2:0] ST_APPEND = 3'd2;
    localparam logic [2:0] ST_TAIL   = 3'd3;
    localparam logic [2:0] ST_HREAD  = 3'd4;
    localparam logic [2:0] ST_HCHECK = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    // control state
    logic [2:0]           state_reg, state_next;
    logic [LINK_W-1:0]    first_reg, first_next;
    logic [LINK_W-1:0]    last_reg, last_next;
    logic [EPOCH_W-1:0]   epoch_reg, epoch_next;
    logic [TIMEOUT_W-1:0] timeout_reg, timeout_next;
    logic [MAX_CONNS-1:0] member_reg, member_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic                 out_valid_reg, out_valid_next;

    // payload
    logic [FUNC_W-1:0]    func_reg, func_next;
    logic [AW-1:0]        slot_reg, slot_next;
    logic [EPOCH_W-1:0]   dl_reg, dl_next;
    logic [LINK_W-1:0]    tail_reg, tail_next;
    logic [AW-1:0]        pend_slot_reg, pend_slot_next;
    logic                 pend_empty_reg, pend_empty_next;
    result_t              out_reg, out_next;

    // link and deadline memories
    logic [LINK_W-1:0]  next_mem [MAX_CONNS];
    logic [LINK_W-1:0]  prev_mem [MAX_CONNS];
    logic [EPOCH_W-1:0] dl_mem   [MAX_CONNS];
    logic [LINK_W-1:0]  next_rd, prev_rd;
    logic [EPOCH_W-1:0] dl_rd;

    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               next_we, prev_we, dl_we;
    logic [AW-1:0]      next_waddr, prev_waddr, dl_waddr;
    logic [LINK_W-1:0]  next_wdata, prev_wdata;

    logic [FUNC_W-1:0]  in_func;
    logic [SLOT_W-1:0]  in_slot;
    logic               in_ka;
    logic               in_slot_ok;
    logic [EPOCH_W:0]   ka_sum;
    logic [EPOCH_W-1:0] ka_dl;
    logic               out_free;
    logic               expired;
    logic [LINK_W-1:0]  slot_link;

    assign in_func    = s_axis_tdata[1:0];
    assign in_slot    = s_axis_tdata[7:2];
    assign in_ka      = s_axis_tdata[8];
    assign in_slot_ok = ({1'b0, in_slot} < LINK_W'(MAX_CONNS));

    assign ka_sum    = {1'b0, epoch_reg} + (EPOCH_W + 1)'(timeout_reg);
    assign ka_dl     = ka_sum[EPOCH_W] ? EPOCH_MAX : ka_sum[EPOCH_W-1:0];
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign slot_link = LINK_W'(slot_reg);
    // flush reaps unconditionally; tick reaps once the deadline is reached
    assign expired   = (func_reg == FUNC_FLUSH) || (dl_rd <= epoch_reg);

    always_comb
    begin
        state_next      = state_reg;
        first_next      = first_reg;
        last_next       = last_reg;
        epoch_next      = epoch_reg;
        timeout_next    = cfg_we ? cfg_wdata : timeout_reg;
        member_next     = member_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        func_next       = func_reg;
        slot_next       = slot_reg;
        dl_next         = dl_reg;
        tail_next       = tail_reg;
        pend_slot_next  = pend_slot_reg;
        pend_empty_next = pend_empty_reg;
        out_next        = out_reg;
        rd_en           = 1'b0;
        rd_addr         = slot_reg;
        next_we         = 1'b0;
        next_waddr      = slot_reg;
        next_wdata      = NO_LINK;
        prev_we         = 1'b0;
        prev_waddr      = slot_reg;
        prev_wdata      = NO_LINK;
        dl_we           = 1'b0;
        dl_waddr        = slot_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    func_next       = in_func;
                    slot_next       = in_slot[AW-1:0];
                    dl_next         = in_ka ? ka_dl : epoch_reg;
                    pend_valid_next = 1'b0;
                    // fetch the slot's links now, used only if it is queued
                    rd_en           = 1'b1;
                    rd_addr         = in_slot[AW-1:0];
                    if (in_func == FUNC_TICK)
                    begin
                        if (epoch_reg != EPOCH_MAX)
                            epoch_next = epoch_reg + EPOCH_W'(1);
                        state_next = ST_HREAD;
                    end
                    else if (in_func == FUNC_FLUSH)
                        state_next = ST_HREAD;
                    else if (!in_slot_ok)
                        state_next = ST_DONE;
                    else if (member_reg[in_slot[AW-1:0]])
                        state_next = ST_UNLINK;
                    else if (in_func == FUNC_TOUCH)
                        state_next = ST_APPEND;
                    else
                        state_next = ST_DONE;
                end
            end

            ST_UNLINK:
            begin
                if (prev_rd != NO_LINK)
                begin
                    next_we    = 1'b1;
                    next_waddr = prev_rd[AW-1:0];
                    next_wdata = next_rd;
                end
                else
                    first_next = next_rd;
                if (next_rd != NO_LINK)
                begin
                    prev_we    = 1'b1;
                    prev_waddr = next_rd[AW-1:0];
                    prev_wdata = prev_rd;
                end
                else
                    last_next = prev_rd;
                member_next[slot_reg] = 1'b0;
                state_next = (func_reg == FUNC_TOUCH) ? ST_APPEND : ST_DONE;
            end

            ST_APPEND:
            begin
                next_we    = 1'b1;
                next_wdata = NO_LINK;
                prev_we    = 1'b1;
                prev_wdata = last_reg;
                dl_we      = 1'b1;
                tail_next  = last_reg;
                if (last_reg == NO_LINK)
                    first_next = slot_link;
                last_next             = slot_link;
                member_next[slot_reg] = 1'b1;
                state_next = (last_reg != NO_LINK) ? ST_TAIL : ST_DONE;
            end

            ST_TAIL:
            begin
                next_we    = 1'b1;
                next_waddr = tail_reg[AW-1:0];
                next_wdata = slot_link;
                state_next = ST_DONE;
            end

            ST_HREAD:
            begin
                if (first_reg == NO_LINK)
                begin
                    if (func_reg == FUNC_TICK)
                        epoch_next = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = first_reg[AW-1:0];
                    state_next = ST_HCHECK;
                end
            end

            ST_HCHECK:
            begin
                if (!expired)
                    state_next = ST_DONE;
                else if (!pend_valid_reg || out_free)
                begin
                    // previous victim goes out; another one follows it
                    if (pend_valid_reg)
                    begin
                        out_valid_next  = 1'b1;
                        out_next.victim = VICTIM_W'(pend_slot_reg);
                        out_next.reaped = 1'b1;
                        out_next.last   = 1'b0;
                        out_next.empty  = pend_empty_reg;
                    end
                    first_next = next_rd;
                    if (next_rd != NO_LINK)
                    begin
                        prev_we    = 1'b1;
                        prev_waddr = next_rd[AW-1:0];
                        prev_wdata = NO_LINK;
                    end
                    else
                        last_next = NO_LINK;
                    member_next[first_reg[AW-1:0]] = 1'b0;
                    pend_valid_next = 1'b1;
                    pend_slot_next  = first_reg[AW-1:0];
                    pend_empty_next = (next_rd == NO_LINK);
                    state_next      = ST_HREAD;
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_next.victim = pend_valid_reg ? VICTIM_W'(pend_slot_reg) : '0;
                    out_next.reaped = pend_valid_reg;
                    out_next.last   = 1'b1;
                    out_next.empty  = pend_valid_reg ? pend_empty_reg : (first_reg == NO_LINK);
                    state_next      = ST_IDLE;
                end
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            first_reg      <= NO_LINK;
            last_reg       <= NO_LINK;
            epoch_reg      <= '0;
            timeout_reg    <= TIMEOUT_RESET;
            member_reg     <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            first_reg      <= first_next;
            last_reg       <= last_next;
            epoch_reg      <= epoch_next;
            timeout_reg    <= timeout_next;
            member_reg     <= member_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        slot_reg       <= slot_next;
        dl_reg         <= dl_next;
        tail_reg       <= tail_next;
        pend_slot_reg  <= pend_slot_next;
        pend_empty_reg <= pend_empty_next;
        out_reg        <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (next_we)
            next_mem[next_waddr] <= next_wdata;
        if (rd_en)
            next_rd <= next_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (prev_we)
            prev_mem[prev_waddr] <= prev_wdata;
        if (rd_en)
            prev_rd <= prev_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (dl_we)
            dl_mem[dl_waddr] <= dl_reg;
        if (rd_en)
            dl_rd <= dl_mem[rd_addr];
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_reg.empty, out_reg.victim};
    assign m_axis_tuser  = out_reg.reaped;
    assign m_axis_tlast  = out_reg.last;

endmodule

FILE: src/cto_checker.sv
// Port-level checks of the connection timeout queue, bound to the top level
`timescale 1ns / 1ps
`include "connection_timeout_queue_macros.svh"

module cto_checker
    import cto_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tuser,
    input logic                   m_axis_tlast
);

    // a pending beat stays up until taken
    `CTQ_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result beat dropped while stalled")

    // one item at a time: the slave side closes right after a beat
    `CTQ_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second item taken while busy")

    // a beat without a victim carries slot 0 and ends its run
    `CTQ_ASSERT_IMPLY(a_no_victim, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[VICTIM_W-1:0] == '0 && m_axis_tlast, "non-reaped beat malformed")

    // once the queue is empty nothing is left to reap
    `CTQ_ASSERT_IMPLY(a_empty_last, m_axis_tvalid && m_axis_tuser && m_axis_tdata[VICTIM_W], m_axis_tlast, "reap continued past empty queue")

endmodule

bind connection_timeout_queue cto_checker u_cto_checker (.*);
